/* rtl/wls_pkg.sv */
// Shared constants for the wait list set: defaults, command and status codes.
package wls_pkg;

  localparam int MAX_WAITERS_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int PID_W    = 16;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE   = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_PRESENT   = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_REMOVED   = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_WOKEN     = 3'd5;
  localparam status_t ST_NONE      = 3'd6;

endpackage

/* rtl/wait_list_set_unit.sv */
// Wait list set: bounded identifier set with add, remove and wake-all, one slot per step.
// Sequencing: add/remove read and compare the stored slots one by one (removing a middle
// slot also reads the last slot and moves it into the hole); wake reads and emits each
// stored word in turn; an add to a full set, or a command on an empty set, answers at once.
// Throughput: one item at a time; the single slot memory port and its compare set the pace.
// Reset: synchronous, clears the count, sequencer and output valid; slot memory is not
// cleared, since only slots below the count are ever read.
module wait_list_set_unit #(
  parameter int MAX_WAITERS = wls_pkg::MAX_WAITERS_DEF,
  parameter int ID_BITS     = wls_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wls_pkg::CMD_W-1:0]    in_command,
  input  logic [wls_pkg::PID_W-1:0]    in_process_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wls_pkg::STATUS_W-1:0] out_status,
  output logic [wls_pkg::PID_W-1:0]    out_woken_id,
  output logic                         out_last
);

  localparam int SLOT_W = (ID_BITS < wls_pkg::PID_W) ? ID_BITS : wls_pkg::PID_W;
  localparam int IDX_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAITERS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WAITERS);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_LAST_RD, S_LAST_WR, S_WAKE_RD, S_WAKE_EMIT, S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [wls_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]       id_r, id_nxt;
  wls_pkg::status_t        resp_r, resp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  wls_pkg::status_t        out_status_r, out_status_nxt;
  logic [wls_pkg::PID_W-1:0] out_id_r, out_id_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [SLOT_W-1:0] slots [MAX_WAITERS];
  logic [SLOT_W-1:0] rdata_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  logic [SLOT_W-1:0] wr_data;

  logic out_free;
  logic accept;
  logic idx_is_last;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign idx_is_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (we) begin
      slots[wr_addr] <= wr_data;
    end
    rdata_r <= slots[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    rd_addr        = idx_r;
    we             = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = id_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_command;
          id_nxt  = in_process_id[SLOT_W-1:0];
          idx_nxt = '0;
          case (in_command)
            wls_pkg::CMD_ADD: begin
              if (count_r >= CNT_MAX) begin
                resp_nxt  = wls_pkg::ST_FULL;
                state_nxt = S_RESP;
              end else if (count_r == '0) begin
                we        = 1'b1;
                wr_addr   = '0;
                wr_data   = in_process_id[SLOT_W-1:0];
                count_nxt = CNT_W'(1);
                resp_nxt  = wls_pkg::ST_ADDED;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_RD;
              end
            end
            wls_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                resp_nxt  = wls_pkg::ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_RD;
              end
            end
            wls_pkg::CMD_WAKE: begin
              if (count_r == '0) begin
                resp_nxt  = wls_pkg::ST_NONE;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_WAKE_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (rdata_r == id_r) begin
          if (cmd_r == wls_pkg::CMD_ADD) begin
            resp_nxt  = wls_pkg::ST_PRESENT;
            state_nxt = S_RESP;
          end else if (idx_is_last) begin
            // removing the last slot: nothing to move
            count_nxt = count_r - CNT_W'(1);
            resp_nxt  = wls_pkg::ST_REMOVED;
            state_nxt = S_RESP;
          end else begin
            pos_nxt   = idx_r;
            state_nxt = S_LAST_RD;
          end
        end else if (idx_is_last) begin
          if (cmd_r == wls_pkg::CMD_ADD) begin
            we        = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            wr_data   = id_r;
            count_nxt = count_r + CNT_W'(1);
            resp_nxt  = wls_pkg::ST_ADDED;
          end else begin
            resp_nxt  = wls_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_RESP;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end

      S_LAST_RD: begin
        rd_addr   = IDX_W'(count_r - CNT_W'(1));
        state_nxt = S_LAST_WR;
      end

      S_LAST_WR: begin
        // move the last word into the freed slot
        we        = 1'b1;
        wr_addr   = pos_r;
        wr_data   = rdata_r;
        count_nxt = count_r - CNT_W'(1);
        resp_nxt  = wls_pkg::ST_REMOVED;
        state_nxt = S_RESP;
      end

      S_WAKE_RD: begin
        rd_addr   = idx_r;
        state_nxt = S_WAKE_EMIT;
      end

      S_WAKE_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = wls_pkg::ST_WOKEN;
          out_id_nxt     = wls_pkg::PID_W'(rdata_r);
          out_last_nxt   = idx_is_last;
          if (idx_is_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_WAKE_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_id_nxt     = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_woken_id = out_id_r;
  assign out_last     = out_last_r;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the wait list set: directed, back-pressure and random commands.
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS = wls_pkg::MAX_WAITERS_DEF;
  localparam int PID_W = wls_pkg::PID_W;
  localparam int CMD_W = wls_pkg::CMD_W;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    wls_pkg::status_t status;
    logic [PID_W-1:0] woken_id;
    logic             last;
  } outcome_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [CMD_W-1:0]             in_command;
  logic [PID_W-1:0]             in_process_id;
  logic                         out_valid;
  logic                         out_stall;
  logic [wls_pkg::STATUS_W-1:0] out_status;
  logic [PID_W-1:0]             out_woken_id;
  logic                         out_last;

  // mirror of the stored set and the words it is expected to produce
  logic [PID_W-1:0] mirror_ids [SLOTS];
  int               mirror_count;
  outcome_t         outcome_q[$];

  int   tx_idle_pct = 27;
  int   rx_idle_pct = 27;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_cycles = 0;
  int   fail_count = 0;
  int   cmds_sent = 0;
  int   unused_sent = 0;
  int   words_checked = 0;
  int   full_rejects = 0;
  int   full_wakes = 0;

  wait_list_set_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_process_id (in_process_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_woken_id  (out_woken_id),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Work out the words one accepted command produces and update the mirror.
  task automatic apply_wait_cmd(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid);
    int       hit;
    outcome_t o;
    hit = -1;
    for (int i = 0; i < mirror_count; i++)
      if (hit < 0 && mirror_ids[i] == pid) hit = i;
    o.woken_id = '0;
    o.last     = 1'b1;
    case (cmd)
      wls_pkg::CMD_ADD: begin
        if (mirror_count >= SLOTS) begin
          o.status = wls_pkg::ST_FULL;
          full_rejects++;
        end else if (hit >= 0) begin
          o.status = wls_pkg::ST_PRESENT;
        end else begin
          mirror_ids[mirror_count] = pid;
          mirror_count++;
          o.status = wls_pkg::ST_ADDED;
        end
        outcome_q.push_back(o);
      end
      wls_pkg::CMD_REMOVE: begin
        if (hit < 0) begin
          o.status = wls_pkg::ST_NOT_FOUND;
        end else begin
          // last entry fills the hole
          mirror_ids[hit] = mirror_ids[mirror_count-1];
          mirror_count--;
          o.status = wls_pkg::ST_REMOVED;
        end
        outcome_q.push_back(o);
      end
      wls_pkg::CMD_WAKE: begin
        if (mirror_count == 0) begin
          o.status = wls_pkg::ST_NONE;
          outcome_q.push_back(o);
        end else begin
          if (mirror_count == SLOTS) full_wakes++;
          for (int i = 0; i < mirror_count; i++) begin
            o.status   = wls_pkg::ST_WOKEN;
            o.woken_id = mirror_ids[i];
            o.last     = (i == mirror_count - 1);
            outcome_q.push_back(o);
          end
          mirror_count = 0;
        end
      end
      default: ; // unused code: no word, no change
    endcase
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_process_id <= pid;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_UNUSED) unused_sent++;
    else cmds_sent++;
    apply_wait_cmd(cmd, pid);
  endtask

  // receiver back-pressure: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (outcome_q.size() == 0) begin
        $error("unexpected word: status %0d woken_id %h last %0b",
               out_status, out_woken_id, out_last);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_woken_id !== want.woken_id) begin
          $error("woken_id: expected %h, got %h", want.woken_id, out_woken_id);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [PID_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (mirror_count > 0 && r < 45) return mirror_ids[$urandom_range(mirror_count - 1)];
    if (r < 55) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if (r < 65) return 16'h0001 << $urandom_range(15);
    if (r < 88) return 16'h0100 + PID_W'($urandom_range(23));
    return PID_W'($urandom);
  endfunction

  task automatic test_empty_set();
    send_cmd(wls_pkg::CMD_WAKE, 16'h0000);
    send_cmd(wls_pkg::CMD_REMOVE, 16'h0042);
    send_cmd(CMD_UNUSED, 16'hFFFF);
  endtask

  task automatic test_add_remove();
    send_cmd(wls_pkg::CMD_ADD, 16'h0000);
    send_cmd(wls_pkg::CMD_ADD, 16'hFFFF);
    send_cmd(wls_pkg::CMD_ADD, 16'h0000);
    send_cmd(wls_pkg::CMD_REMOVE, 16'h1234);
    send_cmd(wls_pkg::CMD_REMOVE, 16'h0000);
  endtask

  // fill to capacity, then full rejects (also for a stored id) and a full wake
  task automatic test_full_set();
    for (int i = 0; i < SLOTS - 1; i++) send_cmd(wls_pkg::CMD_ADD, 16'h0001 << i);
    send_cmd(wls_pkg::CMD_ADD, 16'h8000);
    send_cmd(wls_pkg::CMD_ADD, 16'hFFFF);
    send_cmd(wls_pkg::CMD_WAKE, 16'h0000);
  endtask

  task automatic test_output_hold_off();
    tx_idle_pct = 0;
    hold_req    = ~hold_req;
    for (int i = 0; i < SLOTS; i++) send_cmd(wls_pkg::CMD_ADD, 16'hA500 + PID_W'(i));
    send_cmd(wls_pkg::CMD_ADD, 16'h5A5A);
    send_cmd(wls_pkg::CMD_WAKE, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_cmd(wls_pkg::CMD_REMOVE, pick_id());
    tx_idle_pct = 27;
  endtask

  task automatic test_random_mix(input int n_items);
    int wake_pct;
    int r;
    wake_pct = 5;
    for (int n = 0; n < n_items; n++) begin
      if (n % 30 == 0) wake_pct = $urandom_range(1, 12);
      // one stretch with no idling on either side
      if (n == n_items / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (n == n_items / 3 + 70) begin
        tx_idle_pct = 27;
        rx_idle_pct = 27;
      end
      r = $urandom_range(99);
      if (r < 3) send_cmd(CMD_UNUSED, PID_W'($urandom));
      else if (r < 3 + wake_pct) send_cmd(wls_pkg::CMD_WAKE, PID_W'($urandom));
      else if (r < 33 + wake_pct) send_cmd(wls_pkg::CMD_REMOVE, pick_id());
      else send_cmd(wls_pkg::CMD_ADD, pick_id());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = wls_pkg::CMD_ADD;
    in_process_id = '0;
    mirror_count  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_set();
    test_add_remove();
    test_full_set();
    test_output_hold_off();
    test_random_mix(330);

    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands plus %0d unused codes, %0d result words checked.",
             cmds_sent, unused_sent, words_checked);
    $display("Adds rejected on a full set: %0d, wakes of a full set: %0d.",
             full_rejects, full_wakes);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* wait_list_set_unit.f */
rtl/wls_pkg.sv
rtl/wait_list_set_unit.sv
bench/tb_top.sv
